[src/sida_pkg.sv]
package sida_pkg;

  // Width of the signed input value
  localparam int VALUE_BITS = 32;

  // Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1)
  localparam int DIGITS = (VALUE_BITS * 3) / 10 + 1;
  localparam int IDX_W  = $clog2(DIGITS);
  localparam int STEP_W = $clog2(VALUE_BITS);

  // ASCII codes, cut to the 6-bit character field
  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_NINE  = 6'd57;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

endpackage

[src/signed_int_to_decimal_ascii.sv]
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | value_i (VALUE_BITS, signed)
// out     | output    | out_valid_o / out_stall_i| character_o (6), last_o (1)
//
// One number goes through a beat capture, VALUE_BITS double-dabble shift
// steps in a single BCD adjust-and-shift unit, a scan that skips leading
// zero digits while keeping the units digit, then one character sent per
// cycle while the output is not stalled. in_stall_o stays high until the
// last character of a number has been loaded into the output register.
// rst_ni clears the sequencer and the output valid asynchronously.
// A stall on out holds the current beat and pauses the character sequencer.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  output logic [5:0]                   character_o,
  output logic                         last_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  state_e                  state_q;
  logic [VALUE_BITS-1:0]   mag_q;
  logic [VALUE_BITS-1:0]   mag_in;
  logic                    neg_q;
  logic [STEP_W-1:0]       step_q;
  logic [IDX_W-1:0]        idx_q;
  logic [3:0]              bcd_q [DIGITS];
  logic [3:0]              adj   [DIGITS];
  logic [3:0]              bcd_d [DIGITS];
  logic [5:0]              char_q;
  logic                    last_q;
  logic                    oval_q;
  logic                    out_free;
  logic                    emit;
  logic                    in_beat;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_free    = !oval_q || !out_stall_i;
  assign emit        = out_free && (state_q == ST_SIGN || state_q == ST_DIGIT);
  assign character_o = char_q;
  assign last_o      = last_q;
  assign out_valid_o = oval_q;

  // Magnitude; the most negative value maps onto itself as unsigned
  assign mag_in = value_i[VALUE_BITS-1] ? (~value_i + VALUE_BITS'(1)) : value_i;

  // Double-dabble step: add 3 to digits of 5 or more, then shift one bit in
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      adj[k] = (bcd_q[k] >= 4'd5) ? (bcd_q[k] + 4'd3) : bcd_q[k];
    end
    bcd_d[0] = {adj[0][2:0], mag_q[VALUE_BITS-1]};
    for (int k = 1; k < DIGITS; k++) begin
      bcd_d[k] = {adj[k][2:0], adj[k-1][3]};
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      step_q  <= '0;
      idx_q   <= '0;
      char_q  <= '0;
      last_q  <= 1'b0;
      oval_q  <= 1'b0;
      for (int k = 0; k < DIGITS; k++) begin
        bcd_q[k] <= '0;
      end
    end else begin
      // load a new beat when a character goes out, drop it once taken
      if (emit) begin
        oval_q <= 1'b1;
      end else if (!out_stall_i) begin
        oval_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            mag_q   <= mag_in;
            neg_q   <= value_i[VALUE_BITS-1];
            step_q  <= STEP_W'(VALUE_BITS - 1);
            for (int k = 0; k < DIGITS; k++) begin
              bcd_q[k] <= '0;
            end
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          for (int k = 0; k < DIGITS; k++) begin
            bcd_q[k] <= bcd_d[k];
          end
          mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
          if (step_q == '0) begin
            idx_q   <= IDX_W'(DIGITS - 1);
            state_q <= ST_SKIP;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        ST_SKIP: begin
          // drop leading zeros, keeping at least the units digit
          if (bcd_q[idx_q] == 4'd0 && idx_q != '0) begin
            idx_q <= idx_q - IDX_W'(1);
          end else begin
            state_q <= neg_q ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            char_q  <= CHAR_MINUS;
            last_q  <= 1'b0;
            state_q <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (out_free) begin
            char_q <= CHAR_ZERO | {2'b00, bcd_q[idx_q]};
            last_q <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q - IDX_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/sida_chk.sv]
module sida_chk
  import sida_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic signed [VALUE_BITS-1:0] value_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [5:0]                   character_o,
  input logic                         last_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o) && $stable(last_o))
    else $error("output beat changed under stall");

  // After an input beat the block is busy converting
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // Characters are a minus sign or a decimal digit
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> character_o == CHAR_MINUS ||
                    (character_o >= CHAR_ZERO && character_o <= CHAR_NINE))
    else $error("bad character code");

  // The sign never ends a number
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && character_o == CHAR_MINUS |-> !last_o)
    else $error("minus sign marked last");

endmodule

bind signed_int_to_decimal_ascii sida_chk u_sida_chk (.*);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import sida_pkg::*;

  localparam int DIRECTED_ROWS = 20;
  localparam int PHASE_ITEMS   = 120;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 80;

  // One expected character beat
  typedef struct packed {
    logic [5:0] ch;
    logic       last;
  } text_char_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [VALUE_BITS-1:0] value_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [5:0]            character_o;
  logic                  last_o;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;

  text_char_t expected_text_q[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  // Directed rows; a non-empty string is the text typed in by hand
  logic [31:0] directed_value [DIRECTED_ROWS] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'd999999999, 32'd1000000000, -32'sd1000000000, 32'd1000000001,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555,
    32'hAAAA_AAAA, 32'd123456789, -32'sd987654321, 32'hFFFF_0000
  };
  string directed_text [DIRECTED_ROWS] = '{
    "0", "1", "-1", "", "", "", "", "",
    "", "1000000000", "", "",
    "2147483647", "-2147483648", "-2147483647", "",
    "", "", "", ""
  };

  signed_int_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_o (character_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Decimal text of a signed value, most significant character first
  function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
    logic            neg;
    longint unsigned mag;
    logic [3:0]      digit [DIGITS];
    int              n;
    neg = v[VALUE_BITS-1];
    mag = neg ? ((64'd1 << VALUE_BITS) - 64'(v)) : 64'(v);
    n = 0;
    do begin
      digit[n] = 4'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0);
    if (neg) expected_text_q.push_back(text_char_t'{ch: CHAR_MINUS, last: 1'b0});
    for (int i = n - 1; i >= 0; i--)
      expected_text_q.push_back(text_char_t'{ch: CHAR_ZERO + 6'(digit[i]),
                                             last: (i == 0)});
  endfunction

  function automatic void push_literal_text(input string text);
    for (int i = 0; i < text.len(); i++)
      expected_text_q.push_back(text_char_t'{ch: 6'(text[i]),
                                             last: (i == text.len() - 1)});
  endfunction

  // Mix of full-range values, short numbers, decade edges and values near the signed limits
  function automatic logic [31:0] random_value();
    int unsigned kind;
    int unsigned k;
    logic [31:0] mag;
    kind = $urandom_range(4);
    mag = 32'd1;
    case (kind)
      1: begin
        k = $urandom_range(1, 9);
        repeat (k) mag = mag * 10;
        mag = $urandom_range(mag - 1, 0);
        random_value = $urandom_range(1) ? -mag : mag;
      end
      2: begin
        k = $urandom_range(0, 9);
        repeat (k) mag = mag * 10;
        mag = mag + $urandom_range(2) - 1;
        random_value = $urandom_range(1) ? -mag : mag;
      end
      3: begin
        if ($urandom_range(1)) random_value = 32'h8000_0000 + $urandom_range(3);
        else random_value = 32'h7FFF_FFFF - $urandom_range(3);
      end
      default: random_value = $urandom();
    endcase
  endfunction

  // One input beat; expectations are queued at the accepting edge
  task automatic send_value(input logic [31:0] v, input string text);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (text.len() != 0) push_literal_text(text);
    else predict_text(v);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Output beat check
  always @(posedge clk_i) begin : check_output
    text_char_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_text_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat char=%0d last=%0b",
                                  character_o, last_o));
      end else begin
        want = expected_text_q.pop_front();
        if (character_o !== want.ch)
          report_mismatch($sformatf("character got %0d want %0d",
                                    character_o, want.ch));
        if (last_o !== want.last)
          report_mismatch($sformatf("last got %0b want %0b (char %0d)",
                                    last_o, want.last, want.ch));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase  = '{0, 53, 0, 36};
    stall_by_phase = '{0, 0, 53, 36};

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, no idling
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_value(directed_value[r], directed_text[r]);

    // Random values across idle/stall phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_value(random_value(), "");
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (expected_text_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_text_q.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived",
                                expected_text_q.size()));
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
